FILE: sv/assert_macros.svh
// assertion macros shared by the scanner modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ZLHS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("zlhs assertion failed");

// checked on every clock edge, reset included
`define ZLHS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("zlhs assertion failed");

`endif

FILE: sv/zlhs_pkg.sv
// types and constants of the zip local header scanner
`timescale 1ns / 1ps

package zlhs_pkg;

  localparam logic [7:0]  MARK_FIRST  = 8'h50;
  localparam logic [7:0]  MARK_SECOND = 8'h4b;
  localparam logic [15:0] TYPE_LOCAL  = 16'h0304;
  localparam logic [15:0] TYPE_EOCD   = 16'h0506;
  localparam logic [4:0]  HEADER_LEN  = 5'd26;
  localparam logic [4:0]  LEN_LO_OFS  = 5'd22;
  localparam logic [4:0]  LEN_HI_OFS  = 5'd23;

  typedef enum logic [2:0] {
    PH_SEARCH0 = 3'd0,
    PH_SEARCH1 = 3'd1,
    PH_TYPE0   = 3'd2,
    PH_TYPE1   = 3'd3,
    PH_HEADER  = 3'd4,
    PH_NAME    = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    KIND_NAME   = 3'd0,
    KIND_EMPTY  = 3'd1,
    KIND_NOARC  = 3'd2,
    KIND_BROKEN = 3'd3,
    KIND_NONE   = 3'd4
  } kind_e;

  typedef struct packed {
    logic       vld;
    kind_e      kind;
    logic [7:0] name_byte;
    logic       name_last;
  } res_t;

endpackage

FILE: sv/zlhs_scan.sv
// scan state registers and the per-beat state update
`timescale 1ns / 1ps
`include "assert_macros.svh"

module zlhs_scan (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic [7:0]       data_byte_i,
  input  logic             end_of_stream_i,
  output zlhs_pkg::res_t   res_o
);

  zlhs_pkg::phase_e phase_q, phase_d;
  logic [4:0]  header_count_q, header_count_d;
  logic [4:0]  hdr_inc;
  logic [7:0]  type_hi_q, type_hi_d;
  logic [7:0]  len_lo_q, len_lo_d;
  logic [15:0] name_rem_q, name_rem_d;
  logic [15:0] name_rem_cur;
  logic        local_seen_q, local_seen_d;
  logic        marker_seen_q, marker_seen_d;
  zlhs_pkg::res_t res;

  always_comb begin
    phase_d        = phase_q;
    header_count_d = header_count_q;
    type_hi_d      = type_hi_q;
    len_lo_d       = len_lo_q;
    name_rem_d     = name_rem_q;
    local_seen_d   = local_seen_q;
    marker_seen_d  = marker_seen_q;
    name_rem_cur   = name_rem_q;
    hdr_inc        = header_count_q + 5'd1;
    res            = '{vld: 1'b0, kind: zlhs_pkg::KIND_NAME, name_byte: 8'd0,
                       name_last: 1'b0};

    unique case (phase_q)
      zlhs_pkg::PH_SEARCH0: begin
        if (data_byte_i == zlhs_pkg::MARK_FIRST) begin
          phase_d = zlhs_pkg::PH_SEARCH1;
        end
      end
      zlhs_pkg::PH_SEARCH1: begin
        if (data_byte_i == zlhs_pkg::MARK_SECOND) begin
          phase_d       = zlhs_pkg::PH_TYPE0;
          marker_seen_d = 1'b1;
        end else if (data_byte_i != zlhs_pkg::MARK_FIRST) begin
          phase_d = zlhs_pkg::PH_SEARCH0;
        end
      end
      zlhs_pkg::PH_TYPE0: begin
        type_hi_d = data_byte_i;
        phase_d   = zlhs_pkg::PH_TYPE1;
      end
      zlhs_pkg::PH_TYPE1: begin
        if ({type_hi_q, data_byte_i} == zlhs_pkg::TYPE_LOCAL) begin
          header_count_d = 5'd0;
          phase_d        = zlhs_pkg::PH_HEADER;
        end else begin
          if ({type_hi_q, data_byte_i} == zlhs_pkg::TYPE_EOCD && !local_seen_q) begin
            res.vld  = 1'b1;
            res.kind = zlhs_pkg::KIND_NOARC;
          end
          phase_d = zlhs_pkg::PH_SEARCH0;
        end
      end
      zlhs_pkg::PH_HEADER: begin
        if (header_count_q == zlhs_pkg::LEN_LO_OFS) begin
          len_lo_d = data_byte_i;
        end else if (header_count_q == zlhs_pkg::LEN_HI_OFS) begin
          name_rem_cur = {data_byte_i, len_lo_q};
        end
        name_rem_d     = name_rem_cur;
        header_count_d = hdr_inc;
        if (hdr_inc >= zlhs_pkg::HEADER_LEN) begin
          header_count_d = 5'd0;
          local_seen_d   = 1'b1;
          if (name_rem_cur == 16'd0) begin
            res.vld  = 1'b1;
            res.kind = zlhs_pkg::KIND_EMPTY;
            phase_d  = zlhs_pkg::PH_SEARCH0;
          end else begin
            phase_d = zlhs_pkg::PH_NAME;
            // name cut off before its first byte
            if (end_of_stream_i) begin
              res.vld  = 1'b1;
              res.kind = zlhs_pkg::KIND_EMPTY;
            end
          end
        end
      end
      zlhs_pkg::PH_NAME: begin
        res.vld       = 1'b1;
        res.kind      = zlhs_pkg::KIND_NAME;
        res.name_byte = data_byte_i;
        res.name_last = (name_rem_q <= 16'd1) || end_of_stream_i;
        name_rem_d    = name_rem_q - 16'd1;
        if (name_rem_d == 16'd0) begin
          phase_d = zlhs_pkg::PH_SEARCH0;
        end
      end
      default: begin
        phase_d = zlhs_pkg::PH_SEARCH0;
      end
    endcase

    if (end_of_stream_i) begin
      if (phase_d == zlhs_pkg::PH_TYPE0 || phase_d == zlhs_pkg::PH_TYPE1 ||
          phase_d == zlhs_pkg::PH_HEADER) begin
        res.vld  = 1'b1;
        res.kind = zlhs_pkg::KIND_BROKEN;
      end
      if (!marker_seen_d) begin
        res.vld  = 1'b1;
        res.kind = zlhs_pkg::KIND_NONE;
      end
      phase_d        = zlhs_pkg::PH_SEARCH0;
      header_count_d = 5'd0;
      type_hi_d      = 8'd0;
      len_lo_d       = 8'd0;
      name_rem_d     = 16'd0;
      local_seen_d   = 1'b0;
      marker_seen_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= zlhs_pkg::PH_SEARCH0;
      header_count_q <= 5'd0;
      type_hi_q      <= 8'd0;
      len_lo_q       <= 8'd0;
      name_rem_q     <= 16'd0;
      local_seen_q   <= 1'b0;
      marker_seen_q  <= 1'b0;
    end else if (take_i) begin
      phase_q        <= phase_d;
      header_count_q <= header_count_d;
      type_hi_q      <= type_hi_d;
      len_lo_q       <= len_lo_d;
      name_rem_q     <= name_rem_d;
      local_seen_q   <= local_seen_d;
      marker_seen_q  <= marker_seen_d;
    end
  end

  assign res_o = res;

  `ZLHS_ASSERT(a_eos_clears, take_i && end_of_stream_i |=> phase_q == zlhs_pkg::PH_SEARCH0 && !marker_seen_q && !local_seen_q)
  `ZLHS_ASSERT_ALWAYS(a_name_nonzero, phase_q == zlhs_pkg::PH_NAME |-> name_rem_q != 16'd0)
  `ZLHS_ASSERT_ALWAYS(a_count_in_header, header_count_q != 5'd0 |-> phase_q == zlhs_pkg::PH_HEADER)

endmodule

FILE: sv/zip_local_header_scanner_unit.sv
// top level of the zip local header scanner: scan logic and result register
//
//  channel  direction  handshake               payload
//  in       input      in_valid_i / in_stall_o  data_byte_i, end_of_stream_i
//  out      output     out_valid_o / out_stall_i kind_o, name_byte_o, name_last_o
//
//  one byte beat is taken per cycle unless in_stall_o is high; its result, if any, shows in the next cycle
//  each byte gives at most one result beat, held in the output register
//  in_stall_o is high only while a result waits and out_stall_i is high
//  reset clears the scan state and the output valid; no clearing pass
//  the beat with end_of_stream_i set returns the scan state to its reset values
`timescale 1ns / 1ps
`include "assert_macros.svh"

module zip_local_header_scanner_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_stream_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] kind_o,
  output logic [7:0] name_byte_o,
  output logic       name_last_o
);

  logic           in_take;
  logic           out_valid_q, out_valid_d;
  logic [2:0]     kind_q;
  logic [7:0]     name_byte_q;
  logic           name_last_q;
  zlhs_pkg::res_t res;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_take    = in_valid_i && !in_stall_o;

  zlhs_scan u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (in_take),
    .data_byte_i    (data_byte_i),
    .end_of_stream_i(end_of_stream_i),
    .res_o          (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_take) begin
      out_valid_d = res.vld;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take && res.vld) begin
      kind_q      <= res.kind;
      name_byte_q <= res.name_byte;
      name_last_q <= res.name_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign name_byte_o = name_byte_q;
  assign name_last_o = name_last_q;

  `ZLHS_ASSERT(a_zero_payload, out_valid_o && kind_o != zlhs_pkg::KIND_NAME |-> name_byte_o == 8'd0 && !name_last_o)
  `ZLHS_ASSERT(a_rose_from_take, $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
  `ZLHS_ASSERT(a_fell_when_taken, $fell(out_valid_o) |-> $past(!out_stall_i))

endmodule

FILE: sim/tb_top.sv
// self-checking testbench for the zip local header scanner: directed rows, then random streams
`timescale 1ns / 1ps

module tb_top;

  localparam int STALL_LIMIT = 2000;
  localparam int STREAM_BYTES = 1300;
  localparam int DRAIN_AT = 400;
  localparam int HOLD_AT = 700;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    zlhs_pkg::kind_e kind;
    logic [7:0]      nbyte;
    logic            last;
  } outcome_t;

  typedef struct {
    logic [7:0]      data;
    logic            eos;
    bit              typed;
    zlhs_pkg::kind_e kind;
    logic [7:0]      nbyte;
    logic            last;
  } beat_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] data_byte_i;
  logic       end_of_stream_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [2:0] kind_o;
  logic [7:0] name_byte_o;
  logic       name_last_o;

  zip_local_header_scanner_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .end_of_stream_i(end_of_stream_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .name_byte_o    (name_byte_o),
    .name_last_o    (name_last_o)
  );

  // scanner state mirror
  zlhs_pkg::phase_e ph;
  logic [4:0]  hdr_cnt;
  logic [7:0]  type_hi;
  logic [7:0]  len_lo;
  logic [15:0] name_left;
  bit          local_seen;
  bit          mark_seen;

  outcome_t pending_q [$];
  beat_t    stream_q [$];
  int       items_in;
  int       beats_out;
  int       streams_ended;
  int       errors;
  int       kind_hist [5];
  int       idle_cycles;
  logic     calm;

  assign calm = (items_in >= 1000) && (items_in < 1150);

  beat_t dir_tab [21] = '{
    '{8'h00,                 1'b1, 1'b1, zlhs_pkg::KIND_NONE,   8'h00, 1'b0},
    '{8'hff,                 1'b1, 1'b1, zlhs_pkg::KIND_NONE,   8'h00, 1'b0},
    '{zlhs_pkg::MARK_FIRST,  1'b0, 1'b0, zlhs_pkg::KIND_NAME,   8'h00, 1'b0},
    '{zlhs_pkg::MARK_FIRST,  1'b0, 1'b0, zlhs_pkg::KIND_NAME,   8'h00, 1'b0},
    '{zlhs_pkg::MARK_SECOND, 1'b0, 1'b0, zlhs_pkg::KIND_NAME,   8'h00, 1'b0},
    '{8'h05,                 1'b0, 1'b0, zlhs_pkg::KIND_NAME,   8'h00, 1'b0},
    '{8'h06,                 1'b0, 1'b1, zlhs_pkg::KIND_NOARC,  8'h00, 1'b0},
    '{8'h00,                 1'b1, 1'b0, zlhs_pkg::KIND_NAME,   8'h00, 1'b0},
    '{zlhs_pkg::MARK_FIRST,  1'b0, 1'b0, zlhs_pkg::KIND_NAME,   8'h00, 1'b0},
    '{zlhs_pkg::MARK_SECOND, 1'b0, 1'b0, zlhs_pkg::KIND_NAME,   8'h00, 1'b0},
    '{8'h03,                 1'b1, 1'b1, zlhs_pkg::KIND_BROKEN, 8'h00, 1'b0},
    '{zlhs_pkg::MARK_FIRST,  1'b0, 1'b0, zlhs_pkg::KIND_NAME,   8'h00, 1'b0},
    '{zlhs_pkg::MARK_SECOND, 1'b0, 1'b0, zlhs_pkg::KIND_NAME,   8'h00, 1'b0},
    '{8'h03,                 1'b0, 1'b0, zlhs_pkg::KIND_NAME,   8'h00, 1'b0},
    '{8'h04,                 1'b0, 1'b0, zlhs_pkg::KIND_NAME,   8'h00, 1'b0},
    '{8'ha5,                 1'b1, 1'b1, zlhs_pkg::KIND_BROKEN, 8'h00, 1'b0},
    '{zlhs_pkg::MARK_FIRST,  1'b0, 1'b0, zlhs_pkg::KIND_NAME,   8'h00, 1'b0},
    '{zlhs_pkg::MARK_SECOND, 1'b0, 1'b0, zlhs_pkg::KIND_NAME,   8'h00, 1'b0},
    '{8'h05,                 1'b0, 1'b0, zlhs_pkg::KIND_NAME,   8'h00, 1'b0},
    '{8'h07,                 1'b0, 1'b0, zlhs_pkg::KIND_NAME,   8'h00, 1'b0},
    '{zlhs_pkg::MARK_FIRST,  1'b1, 1'b0, zlhs_pkg::KIND_NAME,   8'h00, 1'b0}
  };

  function automatic outcome_t outcome(zlhs_pkg::kind_e k, logic [7:0] v, logic l);
    outcome_t o;
    o.kind = k;
    o.nbyte = v;
    o.last = l;
    return o;
  endfunction

  function automatic beat_t plain_beat(logic [7:0] d, logic e);
    beat_t s;
    s.data = d;
    s.eos = e;
    s.typed = 1'b0;
    s.kind = zlhs_pkg::KIND_NAME;
    s.nbyte = 8'h00;
    s.last = 1'b0;
    return s;
  endfunction

  function automatic logic [7:0] noise_byte();
    unique case ($urandom_range(0, 7))
      0: return zlhs_pkg::MARK_FIRST;
      1: return zlhs_pkg::MARK_SECOND;
      2: return zlhs_pkg::TYPE_LOCAL[15:8];
      3: return zlhs_pkg::TYPE_LOCAL[7:0];
      4: return zlhs_pkg::TYPE_EOCD[15:8];
      5: return zlhs_pkg::TYPE_EOCD[7:0];
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic clear_scan();
    ph = zlhs_pkg::PH_SEARCH0;
    hdr_cnt = '0;
    type_hi = '0;
    len_lo = '0;
    name_left = '0;
    local_seen = 1'b0;
    mark_seen = 1'b0;
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic eos, ref outcome_t res[$]);
    logic [15:0] t;
    res.delete();
    t = {type_hi, b};
    unique case (ph)
      zlhs_pkg::PH_SEARCH0: begin
        if (b == zlhs_pkg::MARK_FIRST) ph = zlhs_pkg::PH_SEARCH1;
      end
      zlhs_pkg::PH_SEARCH1: begin
        if (b == zlhs_pkg::MARK_SECOND) begin
          ph = zlhs_pkg::PH_TYPE0;
          mark_seen = 1'b1;
        end else if (b != zlhs_pkg::MARK_FIRST) begin
          ph = zlhs_pkg::PH_SEARCH0;
        end
      end
      zlhs_pkg::PH_TYPE0: begin
        type_hi = b;
        ph = zlhs_pkg::PH_TYPE1;
      end
      zlhs_pkg::PH_TYPE1: begin
        if (t == zlhs_pkg::TYPE_LOCAL) begin
          hdr_cnt = '0;
          ph = zlhs_pkg::PH_HEADER;
        end else begin
          if (t == zlhs_pkg::TYPE_EOCD && !local_seen)
            res.push_back(outcome(zlhs_pkg::KIND_NOARC, 8'h00, 1'b0));
          ph = zlhs_pkg::PH_SEARCH0;
        end
      end
      zlhs_pkg::PH_HEADER: begin
        if (hdr_cnt == zlhs_pkg::LEN_LO_OFS) len_lo = b;
        else if (hdr_cnt == zlhs_pkg::LEN_HI_OFS) name_left = {b, len_lo};
        hdr_cnt = hdr_cnt + 5'd1;
        if (hdr_cnt >= zlhs_pkg::HEADER_LEN) begin
          hdr_cnt = '0;
          local_seen = 1'b1;
          if (name_left == 16'd0) begin
            res.push_back(outcome(zlhs_pkg::KIND_EMPTY, 8'h00, 1'b0));
            ph = zlhs_pkg::PH_SEARCH0;
          end else begin
            ph = zlhs_pkg::PH_NAME;
            // stream ends before any name byte
            if (eos) begin
              res.push_back(outcome(zlhs_pkg::KIND_EMPTY, 8'h00, 1'b0));
              clear_scan();
              return;
            end
          end
        end
      end
      zlhs_pkg::PH_NAME: begin
        res.push_back(outcome(zlhs_pkg::KIND_NAME, b, (name_left <= 16'd1) || eos));
        name_left = name_left - 16'd1;
        if (name_left == 16'd0) ph = zlhs_pkg::PH_SEARCH0;
      end
      default: ph = zlhs_pkg::PH_SEARCH0;
    endcase
    if (eos) begin
      if (ph == zlhs_pkg::PH_TYPE0 || ph == zlhs_pkg::PH_TYPE1 || ph == zlhs_pkg::PH_HEADER)
        res.push_back(outcome(zlhs_pkg::KIND_BROKEN, 8'h00, 1'b0));
      if (!mark_seen) res.push_back(outcome(zlhs_pkg::KIND_NONE, 8'h00, 1'b0));
      clear_scan();
    end
  endtask

  // local header with name length nlen; eos lands on byte index cut when 0 <= cut < 30 + nlen
  task automatic push_entry(input logic [15:0] nlen, input int cut);
    int total;
    logic [7:0] b;
    total = 30 + int'(nlen);
    if (cut >= 0 && cut < total) total = cut + 1;
    for (int k = 0; k < total; k++) begin
      unique case (k)
        0: b = zlhs_pkg::MARK_FIRST;
        1: b = zlhs_pkg::MARK_SECOND;
        2: b = zlhs_pkg::TYPE_LOCAL[15:8];
        3: b = zlhs_pkg::TYPE_LOCAL[7:0];
        4 + int'(zlhs_pkg::LEN_LO_OFS): b = nlen[7:0];
        4 + int'(zlhs_pkg::LEN_HI_OFS): b = nlen[15:8];
        default: b = 8'($urandom_range(0, 255));
      endcase
      stream_q.push_back(plain_beat(b, k == cut));
    end
  endtask

  task automatic push_noise(input int n);
    for (int k = 0; k < n; k++) stream_q.push_back(plain_beat(noise_byte(), 1'b0));
  endtask

  task automatic build_stream();
    int r;
    foreach (dir_tab[i]) stream_q.push_back(dir_tab[i]);
    push_entry(16'd0, -1);
    push_entry(16'd3, -1);
    stream_q.push_back(plain_beat(zlhs_pkg::MARK_FIRST, 1'b0));
    stream_q.push_back(plain_beat(zlhs_pkg::MARK_SECOND, 1'b0));
    stream_q.push_back(plain_beat(zlhs_pkg::TYPE_EOCD[15:8], 1'b0));
    stream_q.push_back(plain_beat(zlhs_pkg::TYPE_EOCD[7:0], 1'b0));
    push_entry(16'd5, 29);
    push_entry(16'd6, 32);
    push_entry(16'hffff, 34);
    push_entry(16'd1, -1);
    push_entry(16'd300, -1);
    stream_q.push_back(plain_beat(8'h00, 1'b1));
    while (stream_q.size() < STREAM_BYTES) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        if ($urandom_range(0, 9) == 0)
          push_entry(16'($urandom_range(0, 65535)), 29 + $urandom_range(0, 8));
        else
          push_entry(16'($urandom_range(0, 10)), -1);
        push_noise($urandom_range(0, 3));
      end else if (r < 62) begin
        stream_q.push_back(plain_beat(zlhs_pkg::MARK_FIRST, 1'b0));
        stream_q.push_back(plain_beat(zlhs_pkg::MARK_SECOND, 1'b0));
        stream_q.push_back(plain_beat(zlhs_pkg::TYPE_EOCD[15:8], 1'b0));
        stream_q.push_back(plain_beat(zlhs_pkg::TYPE_EOCD[7:0], 1'b0));
        push_noise($urandom_range(0, 3));
      end else if (r < 77) begin
        push_entry(16'($urandom_range(0, 6)), $urandom_range(2, 32));
      end else if (r < 92) begin
        push_noise($urandom_range(1, 6));
      end else begin
        stream_q.push_back(plain_beat(8'($urandom_range(0, 255)), 1'b1));
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin : sender
    outcome_t got [$];
    beat_t s;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    data_byte_i = 8'h00;
    end_of_stream_i = 1'b0;
    items_in = 0;
    streams_ended = 0;
    clear_scan();
    build_stream();
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (stream_q[i]) begin
      s = stream_q[i];
      if (i == DRAIN_AT) begin
        in_valid_i = 1'b0;
        while (pending_q.size() != 0) @(negedge clk_i);
      end
      while (!calm && $urandom_range(0, 99) < 23) begin
        in_valid_i = 1'b0;
        @(negedge clk_i);
      end
      in_valid_i = 1'b1;
      data_byte_i = s.data;
      end_of_stream_i = s.eos;
      do @(posedge clk_i); while (in_stall_o);
      scan_byte(s.data, s.eos, got);
      if (s.typed) pending_q.push_back(outcome(s.kind, s.nbyte, s.last));
      else foreach (got[j]) pending_q.push_back(got[j]);
      items_in++;
      if (s.eos) streams_ended++;
      @(negedge clk_i);
    end
    in_valid_i = 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("%0d bytes in %0d ended streams, %0d result beats checked",
             items_in, streams_ended, beats_out);
    $display("names %0d, empty names %0d, empty archives %0d, broken %0d, no archive %0d",
             kind_hist[0], kind_hist[1], kind_hist[2], kind_hist[3], kind_hist[4]);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : receiver
    bit held_off;
    held_off = 1'b0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      // long hold-off while the sender keeps offering bytes
      if (!held_off && items_in >= HOLD_AT) begin
        held_off = 1'b1;
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      out_stall_i = !calm && ($urandom_range(0, 99) < 23);
    end
  end

  initial begin
    errors = 0;
    beats_out = 0;
    foreach (kind_hist[k]) kind_hist[k] = 0;
  end

  always @(posedge clk_i) begin : check_out
    outcome_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        $error("result beat with nothing expected: kind %0d byte %0h", kind_o, name_byte_o);
        errors++;
      end else begin
        want = pending_q.pop_front();
        beats_out++;
        kind_hist[int'(want.kind)]++;
        if (kind_o !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind_o);
          errors++;
        end
        if (name_byte_o !== want.nbyte) begin
          $error("name_byte: expected %0h, got %0h", want.nbyte, name_byte_o);
          errors++;
        end
        if (name_last_o !== want.last) begin
          $error("name_last: expected %0b, got %0b", want.last, name_last_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("no beat moved for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_q.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

FILE: zip_local_header_scanner_unit.f
+incdir+sv
sv/zlhs_pkg.sv
sv/zlhs_scan.sv
sv/zip_local_header_scanner_unit.sv
sim/tb_top.sv
